>>> src/utf8d_pkg.sv
// Shared types and constants for the strict UTF-8 decoder.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] CONT_END  = 8'hC0;
  localparam logic [7:0] LEAD3_E0  = 8'hE0;
  localparam logic [7:0] LEAD3_ED  = 8'hED;
  localparam logic [7:0] LEAD4_F0  = 8'hF0;
  localparam logic [7:0] LEAD4_F4  = 8'hF4;

  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_LEAD2 = 3'd1,
    CLS_LEAD3 = 3'd2,
    CLS_LEAD4 = 3'd3,
    CLS_CONT  = 3'd4,
    CLS_BAD   = 3'd5
  } byte_cls_t;

  // allowed range for the second byte of a sequence
  typedef enum logic [2:0] {
    RNG_ANY  = 3'd0,
    RNG_A0BF = 3'd1,
    RNG_809F = 3'd2,
    RNG_90BF = 3'd3,
    RNG_808F = 3'd4
  } cont_rng_t;

  typedef struct packed {
    logic ok_any;
    logic ok_a0bf;
    logic ok_809f;
    logic ok_90bf;
    logic ok_808f;
  } cont_ok_t;

  typedef struct packed {
    byte_cls_t  cls;
    cont_rng_t  rng;
    cont_ok_t   ok;
    logic [6:0] bits;
  } item_t;

endpackage

>>> src/utf8d_front.sv
// Front end: classifies each incoming byte and extracts its payload bits.
`timescale 1ns / 1ps
module utf8d_front (
  input  logic [7:0]       in_byte,
  output utf8d_pkg::item_t item
);

  always_comb begin
    item.cls  = utf8d_pkg::CLS_BAD;
    item.rng  = utf8d_pkg::RNG_ANY;
    item.bits = 7'd0;

    item.ok.ok_any  = (in_byte[7:6] == 2'b10);
    item.ok.ok_a0bf = (in_byte[7:5] == 3'b101);
    item.ok.ok_809f = (in_byte[7:5] == 3'b100);
    item.ok.ok_90bf = (in_byte[7:6] == 2'b10) && (in_byte[5:4] != 2'b00);
    item.ok.ok_808f = (in_byte[7:4] == 4'h8);

    if (!in_byte[7]) begin
      item.cls  = utf8d_pkg::CLS_ASCII;
      item.bits = in_byte[6:0];
    end else if (in_byte < utf8d_pkg::CONT_END) begin
      item.cls  = utf8d_pkg::CLS_CONT;
      item.bits = {1'b0, in_byte[5:0]};
    end else if (in_byte < utf8d_pkg::LEAD2_MIN) begin
      item.cls  = utf8d_pkg::CLS_BAD;
    end else if (in_byte < utf8d_pkg::LEAD3_MIN) begin
      item.cls  = utf8d_pkg::CLS_LEAD2;
      item.bits = {2'b00, in_byte[4:0]};
    end else if (in_byte < utf8d_pkg::LEAD4_MIN) begin
      item.cls  = utf8d_pkg::CLS_LEAD3;
      item.bits = {3'b000, in_byte[3:0]};
      if (in_byte == utf8d_pkg::LEAD3_E0) begin
        item.rng = utf8d_pkg::RNG_A0BF;
      end else if (in_byte == utf8d_pkg::LEAD3_ED) begin
        item.rng = utf8d_pkg::RNG_809F;
      end
    end else if (in_byte <= utf8d_pkg::LEAD4_MAX) begin
      item.cls  = utf8d_pkg::CLS_LEAD4;
      item.bits = {4'b0000, in_byte[2:0]};
      if (in_byte == utf8d_pkg::LEAD4_F0) begin
        item.rng = utf8d_pkg::RNG_90BF;
      end else if (in_byte == utf8d_pkg::LEAD4_F4) begin
        item.rng = utf8d_pkg::RNG_808F;
      end
    end
  end

endmodule

>>> src/utf8d_queue.sv
// Two-entry queue of classified bytes between front and back end.
`timescale 1ns / 1ps
module utf8d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  utf8d_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output utf8d_pkg::item_t pop_item
);

  utf8d_pkg::item_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/utf8d_back.sv
// Back end: sequence state machine, code point assembly and output register.
`timescale 1ns / 1ps
module utf8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  utf8d_pkg::item_t           item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0] out_code_point,
  output logic                       out_bad_sequence
);

  typedef enum logic [3:0] {
    ST_LEAD = 4'b0001,
    ST_C1   = 4'b0010,
    ST_C2   = 4'b0100,
    ST_C3   = 4'b1000
  } dec_state_t;

  dec_state_t                 state_r, state_nxt;
  utf8d_pkg::cont_rng_t       rng_r, rng_nxt;
  logic [utf8d_pkg::CP_W-1:0] part_r, part_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [utf8d_pkg::CP_W-1:0] cp_r, cp_nxt;
  logic                       bad_r, bad_nxt;
  logic                       take, emit, cont_ok;
  logic [utf8d_pkg::CP_W-1:0] shifted;

  assign item_ready       = !out_valid_r || out_ready;
  assign take             = item_valid && item_ready;
  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_bad_sequence = bad_r;
  assign shifted          = {part_r[utf8d_pkg::CP_W-7:0], item.bits[5:0]};

  always_comb begin
    case (rng_r)
      utf8d_pkg::RNG_A0BF: cont_ok = item.ok.ok_a0bf;
      utf8d_pkg::RNG_809F: cont_ok = item.ok.ok_809f;
      utf8d_pkg::RNG_90BF: cont_ok = item.ok.ok_90bf;
      utf8d_pkg::RNG_808F: cont_ok = item.ok.ok_808f;
      default:             cont_ok = item.ok.ok_any;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rng_nxt   = rng_r;
    part_nxt  = part_r;
    emit      = 1'b0;
    cp_nxt    = cp_r;
    bad_nxt   = bad_r;

    if (take) begin
      case (state_r)
        ST_LEAD: begin
          case (item.cls)
            utf8d_pkg::CLS_ASCII: begin
              emit    = 1'b1;
              cp_nxt  = {{(utf8d_pkg::CP_W-7){1'b0}}, item.bits};
              bad_nxt = 1'b0;
            end
            utf8d_pkg::CLS_LEAD2: begin
              state_nxt = ST_C1;
              rng_nxt   = utf8d_pkg::RNG_ANY;
              part_nxt  = {{(utf8d_pkg::CP_W-7){1'b0}}, item.bits};
            end
            utf8d_pkg::CLS_LEAD3: begin
              state_nxt = ST_C2;
              rng_nxt   = item.rng;
              part_nxt  = {{(utf8d_pkg::CP_W-7){1'b0}}, item.bits};
            end
            utf8d_pkg::CLS_LEAD4: begin
              state_nxt = ST_C3;
              rng_nxt   = item.rng;
              part_nxt  = {{(utf8d_pkg::CP_W-7){1'b0}}, item.bits};
            end
            default: begin
              emit    = 1'b1;
              cp_nxt  = '0;
              bad_nxt = 1'b1;
            end
          endcase
        end
        default: begin
          rng_nxt = utf8d_pkg::RNG_ANY;
          if (!cont_ok) begin
            state_nxt = ST_LEAD;
            part_nxt  = '0;
            emit      = 1'b1;
            cp_nxt    = '0;
            bad_nxt   = 1'b1;
          end else if (state_r == ST_C3) begin
            state_nxt = ST_C2;
            part_nxt  = shifted;
          end else if (state_r == ST_C2) begin
            state_nxt = ST_C1;
            part_nxt  = shifted;
          end else begin
            state_nxt = ST_LEAD;
            part_nxt  = '0;
            emit      = 1'b1;
            cp_nxt    = shifted;
            bad_nxt   = 1'b0;
          end
        end
      endcase
    end

    if (take) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LEAD;
      rng_r       <= utf8d_pkg::RNG_ANY;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    bad_r <= bad_nxt;
  end

endmodule

>>> src/utf8_strict_decoder_top.sv
// Top level of the strict UTF-8 decoder.
`timescale 1ns / 1ps
// Decodes a UTF-8 byte stream, one byte per transfer on the input channel,
// at a sustained rate of one byte per clock while the output is not
// stalled. A result transfer appears only when a sequence completes (code
// point, bad_sequence low) or fails (code point zero, bad_sequence high);
// a failing byte is consumed and the decoder then expects a lead byte.
// Overlong forms, surrogates and values above 10FFFF are rejected. A byte
// is written into the two-entry byte queue at its transfer edge and is then
// taken from it by the sequence state machine, which loads the output
// register. The queue lets input keep flowing for two bytes while the
// output is stalled.
module utf8_strict_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0] out_code_point,
  output logic                       out_bad_sequence
);

  utf8d_pkg::item_t cls_item;
  utf8d_pkg::item_t q_item;
  logic             q_valid;
  logic             q_ready;

  utf8d_front u_front (
    .in_byte (in_byte),
    .item    (cls_item)
  );

  utf8d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (cls_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  utf8d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (q_valid),
    .item_ready       (q_ready),
    .item             (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence)
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_sequence) |-> (out_code_point == '0))
    else $error("error result carries a non-zero code point");

  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_sequence) |-> (out_code_point <= 21'h10FFFF))
    else $error("decoded code point above 10FFFF");

  a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_sequence) |-> (out_code_point[20:11] != 10'h01B))
    else $error("decoded code point is a surrogate");

endmodule
